### sv/c2s_pkg.sv
// Shared types and constants for the Cartesian to spherical converter.
// Holds the square-root and CORDIC lane formats and the arctangent table.
// No dependencies.
`default_nettype none

package c2s_pkg;

    // Square-root lanes: 64-bit radicand, 32-bit root
    localparam int ROOT_W = 32;
    localparam int RAD_W  = 2 * ROOT_W;
    localparam int REM_W  = ROOT_W + 1;

    // CORDIC lanes: coordinates scaled to 32 bits, headroom for the gain
    localparam int LANE_W = 36;
    localparam int ACC_W  = 34;
    localparam int ATAN_N = 30;

    // Output angle formats, 32768 stands for pi
    localparam int POL_W   = 16;
    localparam int AZ_W    = 17;
    localparam int ANG_MAX = 32768;
    localparam int ANG_RND = 32768;
    localparam int ANG_SHR = 16;

    localparam logic signed [ACC_W-1:0] ANG_PI = {{(ACC_W-32){1'b0}}, 32'h8000_0000};

    // Partial square root: remainder and root bits found so far
    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } t_root;

    // One vectoring CORDIC lane
    typedef struct packed {
        logic signed [LANE_W-1:0] x;
        logic signed [LANE_W-1:0] y;
        logic signed [ACC_W-1:0]  acc;
        logic                     zero;
    } t_lane;

    // atan(2^-i), 2^31 = pi, rounded to nearest
    function automatic logic signed [ACC_W-1:0] atan_entry(input int idx);
        case (idx)
            0:       atan_entry = ACC_W'(536870912);
            1:       atan_entry = ACC_W'(316933406);
            2:       atan_entry = ACC_W'(167458907);
            3:       atan_entry = ACC_W'(85004756);
            4:       atan_entry = ACC_W'(42667331);
            5:       atan_entry = ACC_W'(21354465);
            6:       atan_entry = ACC_W'(10679838);
            7:       atan_entry = ACC_W'(5340245);
            8:       atan_entry = ACC_W'(2670163);
            9:       atan_entry = ACC_W'(1335087);
            10:      atan_entry = ACC_W'(667544);
            11:      atan_entry = ACC_W'(333772);
            12:      atan_entry = ACC_W'(166886);
            13:      atan_entry = ACC_W'(83443);
            14:      atan_entry = ACC_W'(41722);
            15:      atan_entry = ACC_W'(20861);
            16:      atan_entry = ACC_W'(10430);
            17:      atan_entry = ACC_W'(5215);
            18:      atan_entry = ACC_W'(2608);
            19:      atan_entry = ACC_W'(1304);
            20:      atan_entry = ACC_W'(652);
            21:      atan_entry = ACC_W'(326);
            22:      atan_entry = ACC_W'(163);
            23:      atan_entry = ACC_W'(81);
            24:      atan_entry = ACC_W'(41);
            25:      atan_entry = ACC_W'(20);
            26:      atan_entry = ACC_W'(10);
            27:      atan_entry = ACC_W'(5);
            28:      atan_entry = ACC_W'(3);
            29:      atan_entry = ACC_W'(1);
            default: atan_entry = '0;
        endcase
    endfunction

endpackage

`default_nettype wire

### sv/c2s_root_cell.sv
// One step of the pipelined square-root row: one root bit per lane per cycle while i_en is high.
// Two lanes (planar and total sum of squares) plus the coordinates riding along.
// Depends on c2s_pkg.
`default_nettype none

module c2s_root_cell
    import c2s_pkg::*;
#(
    parameter int STEP   = 0,
    parameter int SIDE_W = 48
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [RAD_W-1:0]  i_plan_rad,
    input  logic [RAD_W-1:0]  i_tot_rad,
    input  t_root             i_plan,
    input  t_root             i_tot,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [RAD_W-1:0]  o_plan_rad,
    output logic [RAD_W-1:0]  o_tot_rad,
    output t_root             o_plan,
    output t_root             o_tot,
    output logic [SIDE_W-1:0] o_side
);

    // radicand bit pair consumed by this step
    localparam int PAIR_HI = RAD_W - 1 - 2 * STEP;

    t_root n_plan;
    t_root n_tot;

    logic              r_valid;
    logic [RAD_W-1:0]  r_plan_rad;
    logic [RAD_W-1:0]  r_tot_rad;
    t_root             r_plan;
    t_root             r_tot;
    logic [SIDE_W-1:0] r_side;

    // restoring step: bring down two bits, try (root*4 + 1)
    function automatic t_root root_step(input t_root p, input logic [1:0] pair);
        logic [REM_W:0] cand;
        logic [REM_W:0] trial;
        logic [REM_W:0] diff;
        logic           ge;
        t_root          q;
        cand   = {p.rem[ROOT_W-1:0], pair};
        trial  = {p.root, 2'b01};
        diff   = cand - trial;
        ge     = (cand >= trial);
        q.rem  = ge ? diff[REM_W-1:0] : cand[REM_W-1:0];
        q.root = {p.root[ROOT_W-2:0], ge};
        return q;
    endfunction

    always_comb begin
        n_plan = root_step(i_plan, i_plan_rad[PAIR_HI -: 2]);
        n_tot  = root_step(i_tot,  i_tot_rad[PAIR_HI -: 2]);
    end

    // beat valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_plan_rad <= i_plan_rad;
            r_tot_rad  <= i_tot_rad;
            r_plan     <= n_plan;
            r_tot      <= n_tot;
            r_side     <= i_side;
        end
    end

    assign o_valid    = r_valid;
    assign o_plan_rad = r_plan_rad;
    assign o_tot_rad  = r_tot_rad;
    assign o_plan     = r_plan;
    assign o_tot      = r_tot;
    assign o_side     = r_side;

endmodule

`default_nettype wire

### sv/c2s_cordic_cell.sv
// One micro-rotation of the vectoring CORDIC row, both lanes (azimuth, polar).
// Rounded radius rides along as side data.
// Depends on c2s_pkg.
`default_nettype none

module c2s_cordic_cell
    import c2s_pkg::*;
#(
    parameter int STAGE  = 0,
    parameter int SIDE_W = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  t_lane             i_az,
    input  t_lane             i_po,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output t_lane             o_az,
    output t_lane             o_po,
    output logic [SIDE_W-1:0] o_side
);

    localparam logic signed [ACC_W-1:0] ATAN = atan_entry(STAGE);

    t_lane n_az;
    t_lane n_po;

    logic              r_valid;
    t_lane             r_az;
    t_lane             r_po;
    logic [SIDE_W-1:0] r_side;

    // rotate towards y = 0; shifts floor towards minus infinity
    function automatic t_lane rotate(input t_lane a);
        logic signed [LANE_W-1:0] xa;
        logic signed [LANE_W-1:0] ya;
        logic signed [LANE_W-1:0] dx;
        logic signed [LANE_W-1:0] dy;
        t_lane                    q;
        xa = a.x;
        ya = a.y;
        dx = ya >>> STAGE;
        dy = xa >>> STAGE;
        q  = a;
        if (!ya[LANE_W-1]) begin
            q.x   = xa + dx;
            q.y   = ya - dy;
            q.acc = a.acc + ATAN;
        end else begin
            q.x   = xa - dx;
            q.y   = ya + dy;
            q.acc = a.acc - ATAN;
        end
        return q;
    endfunction

    always_comb begin
        n_az = rotate(i_az);
        n_po = rotate(i_po);
    end

    // beat valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_az   <= n_az;
            r_po   <= n_po;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_az    = r_az;
    assign o_po    = r_po;
    assign o_side  = r_side;

endmodule

`default_nettype wire

### sv/cartesian_to_spherical.sv
// Cartesian to spherical converter, top level.
// Uses c2s_pkg, c2s_root_cell and c2s_cordic_cell.
//
// Takes one point (x, y, z) per clock while o_ready is high and returns its
// rounded radius, its polar angle acos(z/r) in 0..32768 and its azimuth
// atan2(y, x) in -32768..32768, with 32768 standing for pi; the origin gives
// all zeros. The datapath is a pipeline: a squaring register and a summing
// register, a row of 32 square-root cells (one root bit per cell per cycle
// while the pipeline is not held, giving the radius and the planar length
// rho), one pre-rotation stage and a row of CORDIC_STAGES vectoring cells,
// capped at ATAN_N. A two-entry output buffer keeps o_ready high while one
// result waits; only with both entries full does the whole pipeline hold and
// o_ready drop.
`default_nettype none

module cartesian_to_spherical
    import c2s_pkg::*;
#(
    parameter int COORD_WIDTH   = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [COORD_WIDTH-1:0] i_x_coord,
    input  logic signed [COORD_WIDTH-1:0] i_y_coord,
    input  logic signed [COORD_WIDTH-1:0] i_z_coord,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic        [COORD_WIDTH-1:0] o_radius,
    output logic        [POL_W-1:0]       o_polar_angle,
    output logic signed [AZ_W-1:0]        o_azimuth
);

    localparam int GUARD    = 32 - COORD_WIDTH;
    localparam int SQ_W     = 2 * COORD_WIDTH - 1;
    localparam int SUM_W    = 2 * COORD_WIDTH;
    localparam int SIDE_W   = 3 * COORD_WIDTH;
    localparam int NUM_ITER = (CORDIC_STAGES < ATAN_N) ? CORDIC_STAGES : ATAN_N;
    localparam int ANG_W    = ACC_W - ANG_SHR;

    logic en;

    // ---------------- squaring and sums ----------------
    logic signed [SUM_W-1:0] n_prod_x;
    logic signed [SUM_W-1:0] n_prod_y;
    logic signed [SUM_W-1:0] n_prod_z;
    logic        [SUM_W-1:0] n_planar;
    logic        [SUM_W-1:0] n_total;

    logic                   r_s1_valid;
    logic [SIDE_W-1:0]      r_s1_side;
    logic [SQ_W-1:0]        r_sq_x;
    logic [SQ_W-1:0]        r_sq_y;
    logic [SQ_W-1:0]        r_sq_z;

    logic                   r_s2_valid;
    logic [SIDE_W-1:0]      r_s2_side;
    logic [SUM_W-1:0]       r_planar;
    logic [SUM_W-1:0]       r_total;

    always_comb begin
        n_prod_x = i_x_coord * i_x_coord;
        n_prod_y = i_y_coord * i_y_coord;
        n_prod_z = i_z_coord * i_z_coord;
        n_planar = SUM_W'(r_sq_x) + SUM_W'(r_sq_y);
        n_total  = n_planar + SUM_W'(r_sq_z);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_side <= {i_x_coord, i_y_coord, i_z_coord};
            r_sq_x    <= n_prod_x[SQ_W-1:0];
            r_sq_y    <= n_prod_y[SQ_W-1:0];
            r_sq_z    <= n_prod_z[SQ_W-1:0];
            r_s2_side <= r_s1_side;
            r_planar  <= n_planar;
            r_total   <= n_total;
        end
    end

    // ---------------- square-root row ----------------
    logic              w_rv    [ROOT_W+1];
    logic [RAD_W-1:0]  w_prad  [ROOT_W+1];
    logic [RAD_W-1:0]  w_trad  [ROOT_W+1];
    t_root             w_plan  [ROOT_W+1];
    t_root             w_tot   [ROOT_W+1];
    logic [SIDE_W-1:0] w_rside [ROOT_W+1];

    // rho is taken from the planar sum on the 32-bit CORDIC scale
    assign w_rv[0]    = r_s2_valid;
    assign w_prad[0]  = RAD_W'(r_planar) << (2 * GUARD);
    assign w_trad[0]  = RAD_W'(r_total);
    assign w_plan[0]  = '0;
    assign w_tot[0]   = '0;
    assign w_rside[0] = r_s2_side;

    for (genvar k = 0; k < ROOT_W; k++) begin : g_root
        c2s_root_cell #(
            .STEP   (k),
            .SIDE_W (SIDE_W)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_en       (en),
            .i_valid    (w_rv[k]),
            .i_plan_rad (w_prad[k]),
            .i_tot_rad  (w_trad[k]),
            .i_plan     (w_plan[k]),
            .i_tot      (w_tot[k]),
            .i_side     (w_rside[k]),
            .o_valid    (w_rv[k+1]),
            .o_plan_rad (w_prad[k+1]),
            .o_tot_rad  (w_trad[k+1]),
            .o_plan     (w_plan[k+1]),
            .o_tot      (w_tot[k+1]),
            .o_side     (w_rside[k+1])
        );
    end

    // ---------------- pre-rotation ----------------
    logic signed [COORD_WIDTH-1:0] sq_xc;
    logic signed [COORD_WIDTH-1:0] sq_yc;
    logic signed [COORD_WIDTH-1:0] sq_zc;
    logic        [ROOT_W-1:0]      n_rnd;
    t_lane                         n_ent_az;
    t_lane                         n_ent_po;

    logic                   r_ent_valid;
    t_lane                  r_ent_az;
    t_lane                  r_ent_po;
    logic [COORD_WIDTH-1:0] r_ent_radius;

    // left half plane: turn by pi first; a zero vector gives angle zero
    function automatic t_lane prerotate(input logic signed [LANE_W-1:0] xv,
                                        input logic signed [LANE_W-1:0] yv);
        t_lane l;
        l.zero = (xv == '0) && (yv == '0);
        if (xv[LANE_W-1]) begin
            l.x   = -xv;
            l.y   = -yv;
            l.acc = yv[LANE_W-1] ? -ANG_PI : ANG_PI;
        end else begin
            l.x   = xv;
            l.y   = yv;
            l.acc = '0;
        end
        return l;
    endfunction

    function automatic logic signed [LANE_W-1:0] scale(input logic signed [COORD_WIDTH-1:0] v);
        logic signed [LANE_W-1:0] e;
        e = {{(LANE_W-COORD_WIDTH){v[COORD_WIDTH-1]}}, v};
        return e <<< GUARD;
    endfunction

    always_comb begin
        {sq_xc, sq_yc, sq_zc} = w_rside[ROOT_W];
        // round half up: bump when remainder exceeds root
        n_rnd    = w_tot[ROOT_W].root
                 + ROOT_W'(w_tot[ROOT_W].rem > REM_W'(w_tot[ROOT_W].root));
        n_ent_az = prerotate(scale(sq_xc), scale(sq_yc));
        n_ent_po = prerotate(scale(sq_zc), LANE_W'(w_plan[ROOT_W].root));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent_valid <= 1'b0;
        end else if (en) begin
            r_ent_valid <= w_rv[ROOT_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ent_az     <= n_ent_az;
            r_ent_po     <= n_ent_po;
            r_ent_radius <= n_rnd[COORD_WIDTH-1:0];
        end
    end

    // ---------------- CORDIC row ----------------
    logic                   w_cv    [NUM_ITER+1];
    t_lane                  w_az    [NUM_ITER+1];
    t_lane                  w_po    [NUM_ITER+1];
    logic [COORD_WIDTH-1:0] w_cside [NUM_ITER+1];

    assign w_cv[0]    = r_ent_valid;
    assign w_az[0]    = r_ent_az;
    assign w_po[0]    = r_ent_po;
    assign w_cside[0] = r_ent_radius;

    for (genvar k = 0; k < NUM_ITER; k++) begin : g_cordic
        c2s_cordic_cell #(
            .STAGE  (k),
            .SIDE_W (COORD_WIDTH)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (w_cv[k]),
            .i_az    (w_az[k]),
            .i_po    (w_po[k]),
            .i_side  (w_cside[k]),
            .o_valid (w_cv[k+1]),
            .o_az    (w_az[k+1]),
            .o_po    (w_po[k+1]),
            .o_side  (w_cside[k+1])
        );
    end

    // ---------------- angle rounding and clamping ----------------
    logic signed [ACC_W-1:0] n_sum_az;
    logic signed [ACC_W-1:0] n_sum_po;
    logic signed [ANG_W-1:0] n_ang_az;
    logic signed [ANG_W-1:0] n_ang_po;
    logic signed [AZ_W-1:0]  n_azimuth;
    logic        [POL_W-1:0] n_polar;

    always_comb begin
        n_sum_az = w_az[NUM_ITER].acc + ACC_W'(ANG_RND);
        n_sum_po = w_po[NUM_ITER].acc + ACC_W'(ANG_RND);
        n_ang_az = $signed(n_sum_az[ACC_W-1:ANG_SHR]);
        n_ang_po = $signed(n_sum_po[ACC_W-1:ANG_SHR]);

        if (w_az[NUM_ITER].zero) begin
            n_azimuth = '0;
        end else if (n_ang_az > ANG_MAX) begin
            n_azimuth = AZ_W'(ANG_MAX);
        end else if (n_ang_az < -ANG_MAX) begin
            n_azimuth = AZ_W'(-ANG_MAX);
        end else begin
            n_azimuth = n_ang_az[AZ_W-1:0];
        end

        if (w_po[NUM_ITER].zero || n_ang_po[ANG_W-1]) begin
            n_polar = '0;
        end else if (n_ang_po > ANG_MAX) begin
            n_polar = POL_W'(ANG_MAX);
        end else begin
            n_polar = n_ang_po[POL_W-1:0];
        end
    end

    // ---------------- output register and skid entry ----------------
    logic                   r_out_valid;
    logic [COORD_WIDTH-1:0] r_out_radius;
    logic [POL_W-1:0]       r_out_polar;
    logic signed [AZ_W-1:0] r_out_az;
    logic                   r_skid_valid;
    logic [COORD_WIDTH-1:0] r_skid_radius;
    logic [POL_W-1:0]       r_skid_polar;
    logic signed [AZ_W-1:0] r_skid_az;

    logic take;
    logic fresh;

    assign en    = !r_skid_valid;
    assign take  = r_out_valid && i_ready;
    assign fresh = en && w_cv[NUM_ITER];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (fresh) begin
            if (r_out_valid && !take) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (take) begin
                r_out_radius <= r_skid_radius;
                r_out_polar  <= r_skid_polar;
                r_out_az     <= r_skid_az;
            end
        end else if (fresh) begin
            if (r_out_valid && !take) begin
                r_skid_radius <= w_cside[NUM_ITER];
                r_skid_polar  <= n_polar;
                r_skid_az     <= n_azimuth;
            end else begin
                r_out_radius <= w_cside[NUM_ITER];
                r_out_polar  <= n_polar;
                r_out_az     <= n_azimuth;
            end
        end
    end

    assign o_ready       = en;
    assign o_valid       = r_out_valid;
    assign o_radius      = r_out_radius;
    assign o_polar_angle = r_out_polar;
    assign o_azimuth     = r_out_az;

endmodule

`default_nettype wire

### sv/c2s_checker.sv
// Port-level checks for the Cartesian to spherical converter, bound to the top.
// Depends on c2s_pkg for the angle formats.
`default_nettype none

module c2s_checker
    import c2s_pkg::*;
#(
    parameter int COORD_WIDTH = 16
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_ready,
    input logic                          o_valid,
    input logic                          i_ready,
    input logic        [COORD_WIDTH-1:0] o_radius,
    input logic        [POL_W-1:0]       o_polar_angle,
    input logic signed [AZ_W-1:0]        o_azimuth
);

    // reset leaves the output side empty and the input side open
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> o_ready && !o_valid)
        else $error("converter not empty and ready after reset");

    // o_ready only drops when a result is already waiting
    a_stall_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid)
        else $error("input stalled with no result pending");

    // a stalled result beat stays up
    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result beat dropped before acceptance");

    // and its payload does not move
    a_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_radius) && $stable(o_polar_angle)
                                && $stable(o_azimuth))
        else $error("result payload changed while stalled");

    // both angles inside their half-turn ranges
    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_polar_angle <= POL_W'(ANG_MAX))
                    && (o_azimuth <= ANG_MAX) && (o_azimuth >= -ANG_MAX))
        else $error("angle outside half-turn range");

endmodule

bind cartesian_to_spherical c2s_checker #(
    .COORD_WIDTH (COORD_WIDTH)
) u_c2s_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_ready       (o_ready),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_radius      (o_radius),
    .o_polar_angle (o_polar_angle),
    .o_azimuth     (o_azimuth)
);

`default_nettype wire
